// File: sv/ptr_pkg.sv
package ptr_pkg;

	localparam int MAX_DIM = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W = 4;
	localparam int VAL_W = 32;
	localparam int DIM_W = 5;
	localparam int CFG_IDX_W = 2;
	// quotient width of the divider, matched to the dim registers it is compared with
	localparam int QW = 5;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_BEFORE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_TRACED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_AFTER  = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0]        elem_row;
		logic [IDX_W-1:0]        elem_col;
		logic signed [VAL_W-1:0] elem_re;
		logic signed [VAL_W-1:0] elem_im;
	} elem_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_col;
		logic signed [VAL_W-1:0] out_re;
		logic signed [VAL_W-1:0] out_im;
	} res_t;

endpackage

// File: sv/ptr_div.sv
module ptr_div #(
	parameter int DVW = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ptr_pkg::QW-1:0] dividend,
	input  logic [DVW-1:0]        divisor,
	output logic                  done,
	output logic [ptr_pkg::QW-1:0] quo,
	output logic [DVW-1:0]        rem
);
	import ptr_pkg::*;

	localparam int CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] num_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [DVW:0]  trial;
	logic          ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, num_q[QW-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DVW'(trial - {1'b0, dvs_q}) : trial[DVW-1:0];
			num_q <= {num_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

endmodule

// File: sv/partial_trace_reducer_core.sv
// channel | direction | handshake          | payload
// elem    | in        | elem_valid/stall   | ptr_pkg::elem_t (row, col, re, im)
// res     | out       | res_valid/stall    | ptr_pkg::res_t (row, col, re, im)
// cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data (5 bit dims)
//
// One element at a time: each element takes four passes through the shared 5-step
// divider (row and column index decode). An element outside the matrix or off the
// traced diagonal is then dropped; any other goes on to map, address and one
// read-modify-write of the accumulator memory, and one that completes an entry
// also passes through the output state.
// Reset clears control and sets dims to (1, 2, 1); accumulator memory is not cleared.
// A stalled result sits in the output register while the next element is worked; a
// second finished entry waits in the output state and holds off further elements.
module partial_trace_reducer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          elem_valid,
	output logic                          elem_stall,
	input  ptr_pkg::elem_t                elem,
	output logic                          res_valid,
	input  logic                          res_stall,
	output ptr_pkg::res_t                 res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ptr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptr_pkg::DIM_W-1:0]     cfg_data
);
	import ptr_pkg::*;

	localparam int DVW   = DIM_W;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = DATA_WIDTH;
	localparam int SW    = ((DW > VAL_W) ? DW : VAL_W) + 1;
	localparam int MW    = 2 * DIM_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISS  = 4'd1;
	localparam logic [3:0] S_DWAIT = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_MAP   = 4'd4;
	localparam logic [3:0] S_ADDR  = 4'd5;
	localparam logic [3:0] S_RD    = 4'd6;
	localparam logic [3:0] S_ACC   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	localparam logic [1:0] OP_ROW_A = 2'd0;
	localparam logic [1:0] OP_ROW_T = 2'd1;
	localparam logic [1:0] OP_COL_A = 2'd2;
	localparam logic [1:0] OP_COL_T = 2'd3;

	function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] v);
		logic [SW-DW:0] top;
		top = v[SW-1:DW-1];
		if (top == '0 || top == '1)
			return v[DW-1:0];
		else if (v[SW-1])
			return {1'b1, {(DW-1){1'b0}}};
		else
			return {1'b0, {(DW-1){1'b1}}};
	endfunction

	logic [3:0]       state_q;
	logic [1:0]       op_q;
	logic [DIM_W-1:0] dim_before_q, dim_traced_q, dim_after_q;
	logic [DIM_W-1:0] db, dt, da;
	elem_t            elem_q;
	logic [QW-1:0]    q_q, i_q, j_q;
	logic [DVW-1:0]   k_q, l_q, m_q, mc_q;
	logic [IDX_W-1:0] rr_q, rc_q;
	logic [AW-1:0]    addr_q;
	logic [2*DW-1:0]  acc_mem [DEPTH];
	logic [2*DW-1:0]  rd_q;
	logic signed [DW-1:0] accr_q, acci_q;
	logic             res_valid_q;
	res_t             res_q;

	logic             div_start;
	logic             div_done;
	logic [QW-1:0]    div_dividend, div_quo;
	logic [DVW-1:0]   div_divisor, div_rem;

	logic signed [DW-1:0] base_re, base_im, new_re, new_im;
	logic             out_free;
	logic             last;

	assign db = (dim_before_q == '0) ? DIM_W'(1) : dim_before_q;
	assign dt = (dim_traced_q == '0) ? DIM_W'(1) : dim_traced_q;
	assign da = (dim_after_q == '0) ? DIM_W'(1) : dim_after_q;

	assign cfg_ready  = 1'b1;
	assign elem_stall = state_q != S_IDLE;
	assign out_free   = !res_valid_q || !res_stall;
	assign last       = m_q == DVW'(dt - 1'b1);

	always_comb begin
		div_dividend = '0;
		div_divisor  = DVW'(da);
		case (op_q)
			OP_ROW_A: begin
				div_dividend = QW'(elem_q.elem_row);
				div_divisor  = DVW'(da);
			end
			OP_ROW_T, OP_COL_T: begin
				div_dividend = q_q;
				div_divisor  = DVW'(dt);
			end
			OP_COL_A: begin
				div_dividend = QW'(elem_q.elem_col);
				div_divisor  = DVW'(da);
			end
			default: ;
		endcase
	end

	assign div_start = state_q == S_DISS;

	ptr_div #(.DVW(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign base_re = (m_q == '0) ? '0 : rd_q[2*DW-1:DW];
	assign base_im = (m_q == '0) ? '0 : rd_q[DW-1:0];
	assign new_re  = sat(SW'(base_re) + SW'($signed(elem_q.elem_re)));
	assign new_im  = sat(SW'(base_im) + SW'($signed(elem_q.elem_im)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_before_q <= DIM_W'(1);
			dim_traced_q <= DIM_W'(2);
			dim_after_q  <= DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DIM_BEFORE: dim_before_q <= cfg_data;
				REG_DIM_TRACED: dim_traced_q <= cfg_data;
				REG_DIM_AFTER:  dim_after_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ROW_A;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (elem_valid) begin
						state_q <= S_DISS;
						op_q    <= OP_ROW_A;
					end
				end
				S_DISS: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) begin
						if (op_q == OP_COL_T)
							state_q <= S_CHK;
						else begin
							op_q    <= op_q + 1'b1;
							state_q <= S_DISS;
						end
					end
				end
				S_CHK: begin
					if (i_q >= db || j_q >= db || m_q != mc_q)
						state_q <= S_IDLE;
					else
						state_q <= S_MAP;
				end
				S_MAP:  state_q <= S_ADDR;
				S_ADDR: state_q <= S_RD;
				S_RD:   state_q <= S_ACC;
				S_ACC:  state_q <= last ? S_OUT : S_IDLE;
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && elem_valid)
			elem_q <= elem;
		if (state_q == S_DWAIT && div_done) begin
			case (op_q)
				OP_ROW_A: begin
					q_q <= div_quo;
					k_q <= div_rem;
				end
				OP_ROW_T: begin
					i_q <= div_quo;
					m_q <= div_rem;
				end
				OP_COL_A: begin
					q_q <= div_quo;
					l_q <= div_rem;
				end
				OP_COL_T: begin
					j_q  <= div_quo;
					mc_q <= div_rem;
				end
				default: ;
			endcase
		end
		if (state_q == S_MAP) begin
			rr_q <= IDX_W'(MW'(i_q) * MW'(da) + MW'(k_q));
			rc_q <= IDX_W'(MW'(j_q) * MW'(da) + MW'(l_q));
		end
		if (state_q == S_ADDR)
			addr_q <= AW'(32'(rr_q) * 32'(MAX_DIM) + 32'(rc_q));
		if (state_q == S_RD)
			rd_q <= acc_mem[addr_q];
		if (state_q == S_ACC) begin
			acc_mem[addr_q] <= {new_re, new_im};
			accr_q <= new_re;
			acci_q <= new_im;
		end
		if (state_q == S_OUT && out_free) begin
			res_q.out_row <= rr_q;
			res_q.out_col <= rc_q;
			res_q.out_re  <= VAL_W'(SW'(accr_q));
			res_q.out_im  <= VAL_W'(SW'(acci_q));
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DWAIT)
		else $error("divider finished outside wait state");

	a_acc_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |=> state_q == S_OUT || state_q == S_IDLE)
		else $error("bad state after accumulate");

	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output state");
`endif

endmodule

// File: dv/trace_reduce_checker.sv
`timescale 1ns / 100ps

module trace_reduce_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          elem_valid,
	input  logic                          elem_stall,
	input  ptr_pkg::elem_t                elem,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  ptr_pkg::res_t                 res,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ptr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptr_pkg::DIM_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending
);
	localparam int ROW_PITCH = 16;
	localparam int SLOTS = ROW_PITCH * ROW_PITCH;

	logic [ptr_pkg::DIM_W-1:0] dim_before, dim_traced, dim_after;
	logic signed [31:0] part_re [SLOTS];
	logic signed [31:0] part_im [SLOTS];
	ptr_pkg::res_t due_entries [$];
	int mismatches = 0;

	assign fail_count = mismatches;

	function automatic int eff_dim(input logic [ptr_pkg::DIM_W-1:0] d);
		return (d == '0) ? 1 : int'(d);
	endfunction

	function automatic logic signed [31:0] clamp33(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return v[31:0];
	endfunction

	// folds one element into the running sums; returns 1 when an entry completes
	function automatic bit fold_element(input ptr_pkg::elem_t e, output ptr_pkg::res_t r);
		int db, dt, da, row, col, mr, mc, rr, rc, slot;
		logic signed [32:0] s_re, s_im;
		db = eff_dim(dim_before);
		dt = eff_dim(dim_traced);
		da = eff_dim(dim_after);
		row = int'(e.elem_row);
		col = int'(e.elem_col);
		r = '0;
		if (row >= db * dt * da || col >= db * dt * da) return 0;
		mr = (row / da) % dt;
		mc = (col / da) % dt;
		if (mr != mc) return 0;
		rr = (row / da / dt) * da + row % da;
		rc = (col / da / dt) * da + col % da;
		slot = (rr * ROW_PITCH + rc) % SLOTS;
		if (mr == 0) begin
			s_re = {e.elem_re[31], e.elem_re};
			s_im = {e.elem_im[31], e.elem_im};
		end else begin
			s_re = {part_re[slot][31], part_re[slot]} + {e.elem_re[31], e.elem_re};
			s_im = {part_im[slot][31], part_im[slot]} + {e.elem_im[31], e.elem_im};
		end
		part_re[slot] = clamp33(s_re);
		part_im[slot] = clamp33(s_im);
		if (mr != dt - 1) return 0;
		r.out_row = rr[3:0];
		r.out_col = rc[3:0];
		r.out_re = part_re[slot];
		r.out_im = part_im[slot];
		return 1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ptr_pkg::res_t want;
		ptr_pkg::res_t made;
		if (!arst_n) begin
			dim_before <= 5'd1;
			dim_traced <= 5'd2;
			dim_after <= 5'd1;
			due_entries.delete();
			pending <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (due_entries.size() == 0) begin
					flag_mismatch("result with nothing due",
						32'({res.out_row, res.out_col}), '0);
				end else begin
					want = due_entries.pop_front();
					if (res.out_row !== want.out_row)
						flag_mismatch("out_row", 32'(res.out_row), 32'(want.out_row));
					if (res.out_col !== want.out_col)
						flag_mismatch("out_col", 32'(res.out_col), 32'(want.out_col));
					if (res.out_re !== want.out_re)
						flag_mismatch("out_re", res.out_re, want.out_re);
					if (res.out_im !== want.out_im)
						flag_mismatch("out_im", res.out_im, want.out_im);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ptr_pkg::REG_DIM_BEFORE: dim_before <= cfg_data;
					ptr_pkg::REG_DIM_TRACED: dim_traced <= cfg_data;
					ptr_pkg::REG_DIM_AFTER: dim_after <= cfg_data;
					default: ;
				endcase
			end
			if (elem_valid && !elem_stall) begin
				if (fold_element(elem, made)) due_entries.push_back(made);
			end
			pending <= due_entries.size();
		end
	end

endmodule

// File: dv/partial_trace_reducer_core_tb.sv
`timescale 1ns / 100ps

module partial_trace_reducer_core_tb;
	import ptr_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 110;
	localparam int SLOTS = 256;

	logic clk = 1'b0;
	logic arst_n;
	logic elem_valid;
	logic elem_stall;
	elem_t elem;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int cycles = 0;
	int snd_pct = 0;
	int rcv_pct = 0;
	int hold_left = 0;
	logic hold_kick;
	int eff_before = 1;
	int eff_traced = 2;
	int eff_after = 1;
	bit seeded [SLOTS];

	partial_trace_reducer_core dut (
		.clk, .arst_n,
		.elem_valid, .elem_stall, .elem,
		.res_valid, .res_stall, .res,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	trace_reduce_checker checker_i (
		.clk, .arst_n,
		.elem_valid, .elem_stall, .elem,
		.res_valid, .res_stall, .res,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .pending
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_kick) begin
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < rcv_pct);
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h4000_0000;
			5: return 32'hC000_0000;
			default: return $urandom();
		endcase
	endfunction

	// 1 when the element lands on the traced diagonal inside the matrix
	function automatic bit diag_hit(input int r, input int c, output int m, output int slot);
		int rr, rc;
		m = 0;
		slot = 0;
		if (r >= eff_before * eff_traced * eff_after) return 0;
		if (c >= eff_before * eff_traced * eff_after) return 0;
		m = (r / eff_after) % eff_traced;
		if (m != (c / eff_after) % eff_traced) return 0;
		rr = (r / eff_after / eff_traced) * eff_after + r % eff_after;
		rc = (c / eff_after / eff_traced) * eff_after + c % eff_after;
		slot = (rr * 16 + rc) % SLOTS;
		return 1;
	endfunction

	task automatic set_idle(input idle_mode_e mode);
		snd_pct = (mode == IDLE_SEND) ? 58 : (mode == IDLE_BOTH) ? 17 : 0;
		rcv_pct <= (mode == IDLE_RECV) ? 58 : (mode == IDLE_BOTH) ? 17 : 0;
	endtask

	task automatic send_elem(input elem_t item);
		while ($urandom_range(0, 99) < snd_pct) begin
			elem_valid <= 1'b0;
			@(posedge clk);
		end
		elem_valid <= 1'b1;
		elem <= item;
		@(posedge clk);
		while (elem_stall) @(posedge clk);
	endtask

	// skips an add into a sum that no first-slice element has written yet
	task automatic feed(input int r, input int c, input logic [31:0] re, input logic [31:0] im);
		int m, slot;
		bit hit;
		elem_t item;
		hit = diag_hit(r, c, m, slot);
		if (hit && m != 0 && !seeded[slot]) return;
		if (hit && m == 0) seeded[slot] = 1'b1;
		item.elem_row = r[3:0];
		item.elem_col = c[3:0];
		item.elem_re = re;
		item.elem_im = im;
		send_elem(item);
	endtask

	task automatic wait_idle();
		elem_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] b, input logic [DIM_W-1:0] t,
		input logic [DIM_W-1:0] a);
		logic [DIM_W-1:0] junk;
		junk = DIM_W'($urandom_range(0, 31));
		wait_idle();
		write_reg(REG_UNUSED, junk);
		write_reg(REG_DIM_BEFORE, b);
		write_reg(REG_DIM_TRACED, t);
		write_reg(REG_DIM_AFTER, a);
		cfg_valid <= 1'b0;
		eff_before = (b == 0) ? 1 : int'(b);
		eff_traced = (t == 0) ? 1 : int'(t);
		eff_after = (a == 0) ? 1 : int'(a);
	endtask

	// mostly full traced-index runs for one reduced entry, some cut short, some noise
	task automatic run_phase(input int n_items);
		int sent, lim, r0, c0, br, bc, step, blk;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 3) == 0) begin
				feed($urandom_range(0, 15), $urandom_range(0, 15), pick_value(),
					pick_value());
				sent++;
			end else begin
				blk = eff_traced * eff_after;
				lim = eff_before * blk;
				if (lim > 16) lim = 16;
				r0 = $urandom_range(0, lim - 1);
				c0 = $urandom_range(0, lim - 1);
				br = (r0 / blk) * blk + r0 % eff_after;
				bc = (c0 / blk) * blk + c0 % eff_after;
				for (step = 0; step < eff_traced && sent < n_items; step++) begin
					if (br + step * eff_after > 15 || bc + step * eff_after > 15) break;
					if (step > 0 && $urandom_range(0, 19) == 0) break;
					feed(br + step * eff_after, bc + step * eff_after, pick_value(),
						pick_value());
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		elem_valid = 1'b0;
		elem = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_kick = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset dims 1, 2, 1: saturation both ways, off-diagonal, out of range
		set_idle(IDLE_NONE);
		feed(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		feed(1, 1, 32'h7FFF_FFFF, 32'h8000_0000);
		feed(0, 1, pick_value(), pick_value());
		feed(1, 0, pick_value(), pick_value());
		feed(2, 2, pick_value(), pick_value());
		feed(15, 15, pick_value(), pick_value());
		feed(0, 15, pick_value(), pick_value());
		feed(0, 0, 32'hFFFF_FFFF, 32'h0000_0001);
		feed(1, 1, 32'h8000_0000, 32'h7FFF_FFFF);
		// zero dimension counts as one
		set_dims(5'd0, 5'd1, 5'd16);
		feed(15, 15, pick_value(), pick_value());
		feed(0, 15, pick_value(), pick_value());
		feed(15, 0, pick_value(), pick_value());
		feed(10, 5, pick_value(), pick_value());
		// oversized dims: accumulate only, nothing completes; last, dims 16, 1, 1 complete an entry
		set_dims(5'd31, 5'd31, 5'd0);
		feed(0, 0, pick_value(), pick_value());
		feed(7, 7, pick_value(), pick_value());
		feed(15, 15, pick_value(), pick_value());
		set_dims(5'd16, 5'd16, 5'd16);
		feed(15, 15, pick_value(), pick_value());
		feed(3, 12, pick_value(), pick_value());
		set_dims(5'd16, 5'd1, 5'd1);
		feed(5, 9, pick_value(), pick_value());

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: set_dims(5'd2, 5'd2, 5'd2);
				1: set_dims(5'd1, 5'd16, 5'd1);
				2: set_dims(5'd4, 5'd1, 5'd4);
				3: set_dims(5'd0, 5'd0, 5'd0);
				4: set_dims(5'd1, 5'd4, 5'd4);
				5: set_dims(5'd31, 5'd17, 5'd3);
				6: set_dims(5'd2, 5'd3, 5'd2);
				7: set_dims(DIM_W'($urandom_range(0, 4)), DIM_W'($urandom_range(0, 5)),
					DIM_W'($urandom_range(0, 4)));
				default: set_dims(5'd3, 5'd5, 5'd1);
			endcase
			set_idle(idle_mode_e'(p % 4));
			if (p == 2) begin
				// every diagonal element completes here, so the output backs up
				hold_kick <= 1'b1;
				@(posedge clk);
				hold_kick <= 1'b0;
			end
			run_phase(PHASE_ITEMS);
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
